[hdl/pvd_pkg.sv]
// ---------------------------------------------------------------------------
// pvd_pkg
// Shared types, codes and the target-type range check of the prefix-length
// signed varint decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package pvd_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned TypeW   = 4;
  localparam int unsigned StatusW = 3;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StAboveMax  = 3'd1;
  localparam logic [StatusW-1:0] StBelowMin  = 3'd2;
  localparam logic [StatusW-1:0] StTruncated = 3'd3;
  localparam logic [StatusW-1:0] StBadMagic  = 3'd4;

  // Target type codes.
  localparam logic [TypeW-1:0] TyS64  = 4'd0;
  localparam logic [TypeW-1:0] TyU64  = 4'd1;
  localparam logic [TypeW-1:0] TyS32  = 4'd2;
  localparam logic [TypeW-1:0] TyU32  = 4'd3;
  localparam logic [TypeW-1:0] TyS16  = 4'd4;
  localparam logic [TypeW-1:0] TyU16  = 4'd5;
  localparam logic [TypeW-1:0] TyS8   = 4'd6;
  localparam logic [TypeW-1:0] TyU8   = 4'd7;
  localparam logic [TypeW-1:0] TyBool = 4'd8;

  // What a queued record asks the back end to report.
  typedef enum logic [1:0] {
    KindNumber,
    KindTruncated,
    KindBadMagic
  } kind_e;

  typedef struct packed {
    logic [ValueW-1:0] mag;
    logic              sign;
    logic [TypeW-1:0]  ttype;
    kind_e             kind;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

  // A value fits a signed type of width w when bits 63 down to w-1 all agree.
  function automatic logic [StatusW-1:0] check_signed(input logic [ValueW-1:0] v,
                                                      input int unsigned w);
    logic ok;
    ok = 1'b1;
    for (int unsigned i = 0; i < ValueW; i++) begin
      if (i >= w - 1 && v[i] != v[ValueW-1]) begin
        ok = 1'b0;
      end
    end
    if (ok) begin
      return StOk;
    end
    return v[ValueW-1] ? StBelowMin : StAboveMax;
  endfunction

  function automatic logic [StatusW-1:0] check_unsigned(input logic [ValueW-1:0] v,
                                                        input int unsigned w);
    logic over;
    over = 1'b0;
    for (int unsigned i = 0; i < ValueW - 1; i++) begin
      if (i >= w && v[i]) begin
        over = 1'b1;
      end
    end
    if (v[ValueW-1]) begin
      return StBelowMin;
    end
    return over ? StAboveMax : StOk;
  endfunction

  function automatic logic [StatusW-1:0] check_type(input logic [ValueW-1:0] v,
                                                    input logic [TypeW-1:0] t);
    logic [StatusW-1:0] st;
    case (t)
      TyU64:  st = check_unsigned(v, 64);
      TyS32:  st = check_signed(v, 32);
      TyU32:  st = check_unsigned(v, 32);
      TyS16:  st = check_signed(v, 16);
      TyU16:  st = check_unsigned(v, 16);
      TyS8:   st = check_signed(v, 8);
      TyU8:   st = check_unsigned(v, 8);
      TyBool: begin
        st = check_signed(v, 32);
        if (st == StOk && v > 64'd1) begin
          st = StAboveMax;
        end
      end
      default: st = StOk;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

[hdl/pvd_front.sv]
// ---------------------------------------------------------------------------
// pvd_front
// Byte parser: checks the magic byte, decodes headers and gathers the
// payload bytes of each number, then posts one record per finished number,
// truncation or magic fault.
// ---------------------------------------------------------------------------
`default_nettype none

module pvd_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       beat_i,        // a byte beat is taken this cycle
  input  wire  [7:0]                data_byte_i,
  input  wire  [pvd_pkg::TypeW-1:0] target_type_i,
  input  wire                       stream_ended_i,
  output pvd_pkg::push_t            push_o
);

  localparam logic [1:0] PhMagic  = 2'd0;
  localparam logic [1:0] PhHeader = 2'd1;
  localparam logic [1:0] PhBig    = 2'd2;
  localparam logic [1:0] PhLittle = 2'd3;

  logic [1:0]                  phase_q, phase_d;
  logic [3:0]                  left_q, left_d;
  logic [pvd_pkg::ValueW-1:0]  acc_q, acc_d;
  logic                        sign_q, sign_d;
  logic [pvd_pkg::TypeW-1:0]   type_q, type_d;
  logic                        fault_q, fault_d;

  logic [3:0]                  left_dec;
  logic [3:0]                  pos_full;
  logic [2:0]                  pos;
  logic [pvd_pkg::ValueW-1:0]  acc_next;
  pvd_pkg::push_t              push;

  assign left_dec = left_q - 4'd1;
  assign pos_full = 4'd8 - left_q;
  assign pos      = pos_full[2:0];

  always_comb begin
    acc_next = acc_q;
    if (phase_q == PhBig) begin
      acc_next = {acc_q[pvd_pkg::ValueW-9:0], data_byte_i};
    end else begin
      for (int unsigned k = 0; k < 8; k++) begin
        if (pos == 3'(k)) begin
          acc_next[8*k +: 8] = acc_q[8*k +: 8] | data_byte_i;
        end
      end
    end
  end

  always_comb begin
    phase_d        = phase_q;
    left_d         = left_q;
    acc_d          = acc_q;
    sign_d         = sign_q;
    type_d         = type_q;
    fault_d        = fault_q;
    push.valid     = 1'b0;
    push.rec.mag   = acc_next;
    push.rec.sign  = sign_q;
    push.rec.ttype = type_q;
    push.rec.kind  = pvd_pkg::KindNumber;

    if (beat_i) begin
      if (stream_ended_i) begin
        // Every stream end returns the parser to its reset state.
        if (!fault_q) begin
          if (phase_q == PhMagic) begin
            push.valid    = 1'b1;
            push.rec.kind = pvd_pkg::KindBadMagic;
          end else if (phase_q == PhBig || phase_q == PhLittle) begin
            push.valid    = 1'b1;
            push.rec.kind = pvd_pkg::KindTruncated;
          end
        end
        phase_d = PhMagic;
        left_d  = 4'd0;
        acc_d   = '0;
        sign_d  = 1'b0;
        type_d  = '0;
        fault_d = 1'b0;
      end else if (!fault_q) begin
        case (phase_q)
          PhMagic: begin
            if (data_byte_i != 8'h00) begin
              fault_d       = 1'b1;
              push.valid    = 1'b1;
              push.rec.kind = pvd_pkg::KindBadMagic;
            end else begin
              phase_d = PhHeader;
            end
          end
          PhHeader: begin
            sign_d = data_byte_i[7];
            type_d = target_type_i;
            if (!data_byte_i[6]) begin
              // Short form: the whole number is in the header.
              push.valid     = 1'b1;
              push.rec.mag   = {58'd0, data_byte_i[5:0]};
              push.rec.sign  = data_byte_i[7];
              push.rec.ttype = target_type_i;
              acc_d          = '0;
              sign_d         = 1'b0;
            end else if (!data_byte_i[5]) begin
              acc_d   = {59'd0, data_byte_i[4:0]};
              left_d  = 4'd1;
              phase_d = PhBig;
            end else if (!data_byte_i[4]) begin
              acc_d   = {60'd0, data_byte_i[3:0]};
              left_d  = 4'd2;
              phase_d = PhBig;
            end else begin
              acc_d   = '0;
              left_d  = 4'd8;
              phase_d = PhLittle;
            end
          end
          default: begin
            left_d = left_dec;
            if (left_dec == 4'd0) begin
              push.valid = 1'b1;
              phase_d    = PhHeader;
              acc_d      = '0;
              sign_d     = 1'b0;
            end else begin
              acc_d = acc_next;
            end
          end
        endcase
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMagic;
      left_q  <= 4'd0;
      acc_q   <= '0;
      sign_q  <= 1'b0;
      type_q  <= '0;
      fault_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      sign_q  <= sign_d;
      type_q  <= type_d;
      fault_q <= fault_d;
    end
  end

endmodule

`default_nettype wire

[hdl/pvd_queue.sv]
// ---------------------------------------------------------------------------
// pvd_queue
// Short record queue between the parser and the result stage.
// ---------------------------------------------------------------------------
`default_nettype none

module pvd_queue #(
  parameter int unsigned Depth = pvd_pkg::QueueDepth
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire pvd_pkg::push_t  push_i,
  output logic                 full_o,
  output logic                 valid_o,
  output pvd_pkg::rec_t        head_o,
  input  wire                  pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pvd_pkg::rec_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= next_ptr(wr_q);
      end
      if (do_pop) begin
        rd_q <= next_ptr(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/pvd_back.sv]
// ---------------------------------------------------------------------------
// pvd_back
// Result stage: applies the sign, checks the value against its target type
// and holds the result in the output register until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module pvd_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          rec_valid_i,
  input  wire pvd_pkg::rec_t           rec_i,
  output logic                         pop_o,
  output logic                         m_valid_o,
  input  wire                          m_ready_i,
  output logic [pvd_pkg::ValueW-1:0]   value_o,
  output logic [pvd_pkg::StatusW-1:0]  status_o
);

  logic                         valid_q;
  logic [pvd_pkg::ValueW-1:0]   value_q, value_d;
  logic [pvd_pkg::StatusW-1:0]  status_q, status_d;
  logic [pvd_pkg::ValueW-1:0]   signed_val;
  logic                         load;

  assign signed_val = rec_i.sign ? (pvd_pkg::ValueW'(0) - rec_i.mag) : rec_i.mag;
  assign load       = rec_valid_i && (!valid_q || m_ready_i);
  assign pop_o      = load;

  always_comb begin
    case (rec_i.kind)
      pvd_pkg::KindNumber:    status_d = pvd_pkg::check_type(signed_val, rec_i.ttype);
      pvd_pkg::KindTruncated: status_d = pvd_pkg::StTruncated;
      default:                status_d = pvd_pkg::StBadMagic;
    endcase
    value_d = (status_d == pvd_pkg::StOk) ? signed_val : '0;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign m_valid_o = valid_q;
  assign value_o   = value_q;
  assign status_o  = status_q;

endmodule

`default_nettype wire

[hdl/prefix_varint_decoder.sv]
// ---------------------------------------------------------------------------
// prefix_varint_decoder
// Stream decoder for prefix-length signed integers with type range checks.
// ---------------------------------------------------------------------------
// Throughput: one byte beat per cycle, sustained, while results are taken.
// Path: the record of the beat that completes a result is written to the record
// queue first, and the sign/check stage then registers it and presents it.
// The record queue lets the parser run on while the output is stalled.
// Reset (rst_ni low, asynchronous) waits for a new magic byte and drops
// any queued or held result.
`default_nettype none

module prefix_varint_decoder #(
  parameter int unsigned QueueDepth = pvd_pkg::QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,   // [7:0] data_byte, [11:8] target_type, [15:12] zero
  input  wire         s_axis_tlast_i,   // stream_ended
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] value
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  pvd_pkg::push_t push;
  pvd_pkg::rec_t  head;
  logic           full, head_valid, pop, beat;

  assign s_axis_tready_o = !full;
  assign beat            = s_axis_tvalid_i && !full;

  pvd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .data_byte_i    (s_axis_tdata_i[7:0]),
    .target_type_i  (s_axis_tdata_i[11:8]),
    .stream_ended_i (s_axis_tlast_i),
    .push_o         (push)
  );

  pvd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  pvd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (head_valid),
    .rec_i       (head),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .value_o     (m_axis_tdata_o),
    .status_o    (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

[hdl/pvd_checker.sv]
// ---------------------------------------------------------------------------
// pvd_checker
// Port-level checks of the varint decoder, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

module pvd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready_o,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [63:0] m_axis_tdata_o,
  input wire [2:0]  m_axis_tuser_o
);

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // Any non-ok status carries a zero value.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != pvd_pkg::StOk |-> m_axis_tdata_o == 64'd0)
    else $error("nonzero value with error status");

  // Status stays within the defined codes.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tuser_o == pvd_pkg::StOk || m_axis_tuser_o == pvd_pkg::StAboveMax ||
      m_axis_tuser_o == pvd_pkg::StBelowMin || m_axis_tuser_o == pvd_pkg::StTruncated ||
      m_axis_tuser_o == pvd_pkg::StBadMagic)
    else $error("undefined status code");

  // The queue is empty when reset ends, so the input side is open.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> s_axis_tready_o)
    else $error("input not ready after reset");

endmodule

bind prefix_varint_decoder pvd_checker u_pvd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
